// ----- hdl/seven_segment_scan_driver_assert.svh -----
// Assertion macros for the seven-segment scan driver.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("seven-segment scan driver check failed");

// Next-cycle implication, checked outside reset.
`define SSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("seven-segment scan driver check failed");

`endif

// ----- hdl/ssd_pkg.sv -----
// Shared constants, command codes and constant-divide helpers for the scan driver.
package ssd_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_NUMBER = 3'd1,
    CMD_TIME   = 3'd2,
    CMD_OPEN   = 3'd3,
    CMD_DONE   = 3'd4,
    CMD_BLANK  = 3'd5,
    CMD_SET    = 3'd6
  } cmd_t;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned SEG_COUNT  = 7;
  localparam logic [4:0]  SCAN_LAST  = 5'd27;

  localparam logic [3:0] GLYPH_O     = 4'd0;
  localparam logic [3:0] GLYPH_S     = 4'd5;
  localparam logic [3:0] GLYPH_BLANK = 4'd10;
  localparam logic [3:0] GLYPH_P     = 4'd11;
  localparam logic [3:0] GLYPH_E     = 4'd12;
  localparam logic [3:0] GLYPH_N     = 4'd13;
  localparam logic [3:0] GLYPH_D     = 4'd14;
  localparam logic [3:0] GLYPH_T     = 4'd15;

  localparam logic [6:0] SEG_DARK = 7'h7f;

  localparam logic [6:0] GLYPH_ROM [16] = '{
    7'h3f, 7'h30, 7'h5b, 7'h79, 7'h74, 7'h6d, 7'h6f, 7'h38,
    7'h7f, 7'h7d, 7'h00, 7'h5e, 7'h4f, 7'h3e, 7'h73, 7'h47
  };

  // reciprocal multipliers, exact for any 16-bit dividend
  localparam logic [15:0] DIV10_MUL   = 16'd52429;  // >> 19
  localparam logic [16:0] DIV100_MUL  = 17'd83887;  // >> 23
  localparam logic [16:0] DIV1000_MUL = 17'd67109;  // >> 26
  localparam logic [16:0] DIV60_MUL   = 17'd69906;  // >> 22
  localparam logic [16:0] DIV600_MUL  = 17'd111849; // >> 26
  localparam logic [15:0] DIV6_MUL    = 16'd43691;  // >> 18

  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(DIV10_MUL);
    return p[31:19];
  endfunction

  function automatic logic [9:0] div100(input logic [15:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(DIV100_MUL);
    return p[32:23];
  endfunction

  function automatic logic [6:0] div1000(input logic [15:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(DIV1000_MUL);
    return p[32:26];
  endfunction

  function automatic logic [10:0] div60(input logic [15:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(DIV60_MUL);
    return p[32:22];
  endfunction

  function automatic logic [6:0] div600(input logic [15:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(DIV600_MUL);
    return p[32:26];
  endfunction

  function automatic logic [3:0] mod10(input logic [15:0] x);
    logic [15:0] r;
    r = x - 16'(div10(x)) * 16'd10;
    return r[3:0];
  endfunction

  function automatic logic [3:0] mod6(input logic [15:0] x);
    logic [31:0] p;
    logic [15:0] r;
    p = 32'(x) * 32'(DIV6_MUL);
    r = x - 16'(p[31:18]) * 16'd6;
    return r[3:0];
  endfunction

  // scan position of a count 0..27
  function automatic logic [1:0] scan_pos(input logic [4:0] c);
    logic [1:0] p;
    if (c >= 5'd21) begin
      p = 2'd3;
    end else if (c >= 5'd14) begin
      p = 2'd2;
    end else if (c >= 5'd7) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

endpackage

// ----- hdl/seven_segment_scan_driver.sv -----
// Pipeline of 3 register stages: input register, reciprocal-multiply quotients, digit/state
// update into the result register. Throughput one item per cycle while result_ready is
// high; the ready chain lets bubbles close while the result is stalled. rst (synchronous,
// active high) empties the pipeline, clears glyphs to 0000, the scan count to 0, the drive
// to dark, and selects two minute digits.
module seven_segment_scan_driver
  import ssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [3:0]  anode_lines,
  output logic [6:0]  cathode_lines
);

  logic        minute_pair;

  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic [15:0] s1_value;

  logic        s2_valid;
  logic [2:0]  s2_cmd;
  logic [15:0] s2_value;
  logic [12:0] q10;
  logic [9:0]  q100;
  logic [6:0]  q1000;
  logic [10:0] q60;
  logic [6:0]  q600;

  logic        en1, en2, en3;

  logic [3:0]  glyph_store [NUM_DIGITS];
  logic [3:0]  glyph_next  [NUM_DIGITS];
  logic [4:0]  scan_count, scan_count_next;
  logic [3:0]  anode_drive, anode_drive_next;
  logic [6:0]  cathode_drive, cathode_drive_next;

  logic [3:0]  d0, d1, d2, d3, s1_digit, m0, m1;
  logic [4:0]  tick_count;
  logic [1:0]  tick_pos;
  logic [2:0]  tick_seg;
  logic [6:0]  tick_pattern;

  assign en3        = !result_valid || result_ready;
  assign en2        = !s2_valid || en3;
  assign en1        = !s1_valid || en2;
  assign item_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_pair <= 1'b1;
    end else if (cfg_write_en) begin
      minute_pair <= cfg_write_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && item_valid) begin
      s1_cmd   <= cmd;
      s1_value <= value;
    end
  end

  // quotient stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2_cmd   <= s1_cmd;
      s2_value <= s1_value;
      q10      <= div10(s1_value);
      q100     <= div100(s1_value);
      q1000    <= div1000(s1_value);
      q60      <= div60(s1_value);
      q600     <= div600(s1_value);
    end
  end

  // digits
  always_comb begin
    d0       = 4'(s2_value - 16'(q10) * 16'd10);
    d1       = mod10(16'(q10));
    d2       = mod10(16'(q100));
    d3       = mod10(16'(q1000));
    s1_digit = mod6(16'(q10));
    m0       = mod10(16'(q60));
    m1       = (q600 == 7'd0) ? GLYPH_BLANK : mod10(16'(q600));
  end

  // scan step
  always_comb begin
    tick_count   = (scan_count >= SCAN_LAST) ? 5'd0 : scan_count + 5'd1;
    tick_pos     = scan_pos(tick_count);
    tick_seg     = 3'(tick_count - 5'(tick_pos) * 5'd7);
    tick_pattern = GLYPH_ROM[glyph_store[~tick_pos]];
  end

  always_comb begin
    glyph_next         = glyph_store;
    scan_count_next    = scan_count;
    anode_drive_next   = anode_drive;
    cathode_drive_next = cathode_drive;
    if (s2_valid && en3) begin
      case (s2_cmd)
        CMD_TICK: begin
          scan_count_next    = tick_count;
          anode_drive_next   = 4'd0;
          cathode_drive_next = SEG_DARK;
          if (tick_pattern[tick_seg]) begin
            anode_drive_next   = 4'(1 << tick_pos);
            cathode_drive_next = SEG_DARK & ~7'(1 << tick_seg);
          end
        end
        CMD_NUMBER: begin
          glyph_next = '{d0, d1, d2, d3};
        end
        CMD_TIME: begin
          if (minute_pair) begin
            glyph_next = '{d0, s1_digit, m0, m1};
          end else begin
            glyph_next = '{d0, s1_digit, GLYPH_BLANK, m0};
          end
        end
        CMD_OPEN:  glyph_next = '{GLYPH_N, GLYPH_E, GLYPH_P, GLYPH_O};
        CMD_DONE:  glyph_next = '{GLYPH_E, GLYPH_N, GLYPH_O, GLYPH_D};
        CMD_BLANK: glyph_next = '{GLYPH_BLANK, GLYPH_BLANK, GLYPH_BLANK, GLYPH_BLANK};
        CMD_SET:   glyph_next = '{GLYPH_BLANK, GLYPH_T, GLYPH_E, GLYPH_S};
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_store   <= '{4'd0, 4'd0, 4'd0, 4'd0};
      scan_count    <= 5'd0;
      anode_drive   <= 4'd0;
      cathode_drive <= SEG_DARK;
    end else begin
      glyph_store   <= glyph_next;
      scan_count    <= scan_count_next;
      anode_drive   <= anode_drive_next;
      cathode_drive <= cathode_drive_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en3) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid) begin
      anode_lines   <= anode_drive_next;
      cathode_lines <= cathode_drive_next;
    end
  end

  `include "seven_segment_scan_driver_assert.svh"

  `SSD_ASSERT_NOW(a_scan_range, 1'b1, scan_count <= SCAN_LAST)
  `SSD_ASSERT_NOW(a_one_anode, 1'b1, $onehot0(anode_drive))
  `SSD_ASSERT_NOW(a_dark_pairs, anode_drive == 4'd0, cathode_drive == SEG_DARK)
  `SSD_ASSERT_NOW(a_lit_one_seg, anode_drive != 4'd0, $countones(cathode_drive) == 6)
  `SSD_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready && s2_valid, s2_valid)

endmodule
